// ----- hdl/ilp_pkg.sv -----
package ilp_pkg;

   localparam int ILP_MAX_DIGITS_DEFAULT = 64;
   localparam int ILP_QUEUE_DEPTH        = 4;

   localparam int RADIX_W = 5;
   localparam int VALUE_W = 64;
   localparam int DVAL_W  = 6;

   // status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_MINUS_DENIED = 3'd1;
   localparam logic [2:0] ST_BAD_START    = 3'd2;
   localparam logic [2:0] ST_TOO_MANY     = 3'd3;
   localparam logic [2:0] ST_BAD_BOUNDARY = 3'd4;

   localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;

   // classified character, front to back
   typedef struct packed {
      logic              eoi;
      logic [7:0]        sym;
      logic              is_space;
      logic              is_punct;
      logic              is_high;
      logic              is_minus;
      logic              is_comma;
      logic              is_underscore;
      logic              is_x;
      logic              is_dec;
      logic              is_oct;
      logic              is_zero;
      logic [DVAL_W-1:0] dval;
   } ilp_item_type;

   typedef struct packed {
      logic [RADIX_W-1:0] radix;      // already range checked
      logic               prefix_en;
      logic               pos_only;
      logic               comma_skip;
      logic               under_skip;
      logic               space_skip;
      logic               explicit_bnd;
   } ilp_cfg_type;

endpackage

// ----- hdl/ilp_front.sv -----
module ilp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tuser,
   output logic                 push_valid,
   input  logic                 push_ready,
   output ilp_pkg::ilp_item_type push_data
);
   import ilp_pkg::*;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_FF    = 8'h0c;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_DEL   = 8'h7f;

   logic [7:0]   sym;
   ilp_item_type item;

   assign sym = req_tdata;

   always_comb begin
      item               = '0;
      item.eoi           = req_tuser;
      item.sym           = sym;
      item.is_space      = (sym == CH_TAB) || (sym == CH_LF) || (sym == CH_FF) ||
                           (sym == CH_CR) || (sym == CH_SPACE);
      item.is_punct      = (sym >= 8'h21 && sym <= 8'h2f) || (sym >= 8'h3a && sym <= 8'h40) ||
                           (sym >= 8'h5b && sym <= 8'h60) || (sym >= 8'h7b && sym <= 8'h7e);
      item.is_high       = sym >= CH_DEL;
      item.is_minus      = sym == CH_MINUS;
      item.is_comma      = sym == CH_COMMA;
      item.is_underscore = sym == CH_UNDER;
      item.is_x          = (sym == "x") || (sym == "X");
      item.is_dec        = (sym >= "0") && (sym <= "9");
      item.is_oct        = (sym >= "0") && (sym <= "7");
      item.is_zero       = sym == "0";
      if (item.is_dec) begin
         item.dval = DVAL_W'(sym - "0");
      end else if (sym >= "a" && sym <= "z") begin
         item.dval = DVAL_W'(sym - "a" + 8'd10);
      end else if (sym >= "A" && sym <= "Z") begin
         item.dval = DVAL_W'(sym - "A" + 8'd10);
      end else begin
         item.dval = DVAL_W'(36);
      end
   end

   // hold-off flag keeps tready low for the cycle reset is released
   logic live_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= 1'b1;
      end
   end

   assign req_tready = push_ready && live_ff;
   assign push_valid = req_tvalid && live_ff;
   assign push_data  = item;

endmodule

// ----- hdl/ilp_queue.sv -----
module ilp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  ilp_pkg::ilp_item_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output ilp_pkg::ilp_item_type pop_data
);
   import ilp_pkg::*;

   localparam int PTR_W = $clog2(ILP_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ILP_QUEUE_DEPTH + 1);

   ilp_item_type slot_ff [ILP_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(ILP_QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ILP_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ILP_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/ilp_back.sv -----
module ilp_back #(
   parameter int MAX_DIGITS = ilp_pkg::ILP_MAX_DIGITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ilp_pkg::ilp_cfg_type  cfg,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  ilp_pkg::ilp_item_type item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [63:0]          out_value,
   output logic [2:0]           out_status,
   output logic [7:0]           out_stop,
   output logic                 out_end
);
   import ilp_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MINUS,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               out_valid_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic [2:0]         out_status_ff;
   logic [7:0]         out_stop_ff;
   logic               out_end_ff;

   logic               emit;
   logic [VALUE_W-1:0] e_value;
   logic [2:0]         e_status;
   logic [7:0]         e_stop;
   logic               e_end;

   logic               do_take;
   logic               do_start;
   logic [CNT_W-1:0]   take_cnt;
   logic [RADIX_W-1:0] take_radix;
   logic [VALUE_W-1:0] take_acc;
   logic               take_neg;
   logic [VALUE_W-1:0] signed_acc;
   logic [VALUE_W-1:0] prod;
   logic [CNT_W-1:0]   cnt_inc;
   logic               pop;

   assign item_ready = !out_valid_ff || out_ready;
   assign pop        = item_valid && item_ready;

   assign signed_acc = take_neg ? (VALUE_W'(0) - take_acc) : take_acc;
   // one radix step: 64x5 multiply and add
   assign prod       = take_acc * VALUE_W'(take_radix) + VALUE_W'(item.dval);
   assign cnt_inc    = take_cnt + 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      radix_in   = radix_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      emit       = 1'b0;
      e_value    = '0;
      e_status   = ST_OK;
      e_stop     = '0;
      e_end      = 1'b0;
      do_take    = 1'b0;
      do_start   = 1'b0;
      take_cnt   = cnt_ff;
      take_radix = radix_ff;
      take_acc   = acc_ff;
      take_neg   = neg_ff;

      case (phase_ff)
         PH_MINUS: begin
            if (item.eoi) begin
               emit     = 1'b1;
               e_status = ST_BAD_START;
               e_end    = 1'b1;
            end else begin
               do_start = 1'b1;
            end
         end
         PH_ZERO: begin
            if (item.eoi) begin
               emit  = 1'b1;
               e_end = 1'b1;
            end else begin
               phase_in = PH_DIGITS;
               if (item.is_x) begin
                  radix_in = RADIX_HEX;
               end else if (item.is_oct) begin
                  radix_in   = RADIX_OCT;
                  take_radix = RADIX_OCT;
                  do_take    = 1'b1;
               end else begin
                  // the leading zero counts as a digit
                  take_cnt = CNT_W'(1);
                  do_take  = 1'b1;
               end
            end
         end
         PH_DIGITS: begin
            if (item.eoi) begin
               emit    = 1'b1;
               e_value = signed_acc;
               e_end   = 1'b1;
            end else begin
               do_take = 1'b1;
            end
         end
         default: begin
            // idle: start from a clean number, radix latched now
            acc_in     = '0;
            radix_in   = cfg.radix;
            neg_in     = 1'b0;
            cnt_in     = '0;
            take_acc   = '0;
            take_radix = cfg.radix;
            take_neg   = 1'b0;
            take_cnt   = '0;
            if (item.eoi) begin
               emit     = 1'b1;
               e_status = ST_BAD_START;
               e_end    = 1'b1;
            end else if (cfg.space_skip && item.is_space) begin
               phase_in = PH_IDLE;
            end else if (item.is_minus) begin
               if (cfg.pos_only) begin
                  emit     = 1'b1;
                  e_status = ST_MINUS_DENIED;
                  e_stop   = item.sym;
               end else begin
                  neg_in   = 1'b1;
                  phase_in = PH_MINUS;
               end
            end else begin
               do_start = 1'b1;
            end
         end
      endcase

      if (do_start) begin
         if (!item.is_dec) begin
            emit     = 1'b1;
            e_status = ST_BAD_START;
            e_stop   = item.sym;
         end else if (item.is_zero && cfg.prefix_en) begin
            phase_in = PH_ZERO;
         end else begin
            phase_in = PH_DIGITS;
            do_take  = 1'b1;
         end
      end

      if (do_take) begin
         cnt_in = take_cnt;
         if (item.is_space || item.is_high ||
             (!(item.is_comma && cfg.comma_skip) && !(item.is_underscore && cfg.under_skip) &&
              item.dval >= DVAL_W'(take_radix))) begin
            // number ends here
            emit   = 1'b1;
            e_stop = item.sym;
            if (cfg.explicit_bnd && !(item.is_space || item.is_punct)) begin
               e_status = ST_BAD_BOUNDARY;
            end else begin
               e_value = signed_acc;
            end
         end else if ((item.is_comma && cfg.comma_skip) ||
                      (item.is_underscore && cfg.under_skip)) begin
            cnt_in = take_cnt;
         end else if (cnt_inc >= CNT_W'(MAX_DIGITS)) begin
            emit     = 1'b1;
            e_status = ST_TOO_MANY;
            e_stop   = item.sym;
         end else begin
            acc_in = prod;
            cnt_in = cnt_inc;
         end
      end

      if (emit) begin
         phase_in = PH_IDLE;
         acc_in   = '0;
         radix_in = cfg.radix;
         neg_in   = 1'b0;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         acc_ff       <= '0;
         radix_ff     <= RADIX_DEC;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop && emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (pop) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            radix_ff <= radix_in;
            neg_ff   <= neg_in;
            cnt_ff   <= cnt_in;
         end
      end
      if (pop && emit) begin
         out_value_ff  <= e_value;
         out_status_ff <= e_status;
         out_stop_ff   <= e_stop;
         out_end_ff    <= e_end;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_value  = out_value_ff;
   assign out_status = out_status_ff;
   assign out_stop   = out_stop_ff;
   assign out_end    = out_end_ff;

endmodule

// ----- hdl/integer_literal_parser.sv -----
// Streaming integer literal lexer. One character (or an end-of-input mark) enters per
// req transaction and the block sustains one character per clock; each finished number
// yields one rsp transaction with the value, a status, the stop character and an
// end-of-input flag. A character is classified on entry, waits in a four-entry queue and
// is then taken by the parse unit, whose single 64x5 multiply-add per digit sets the
// pace. With the queue empty, the req transaction that ends the number is queued, then
// taken by the parse unit, which registers rsp_tvalid; while a result waits on rsp_tready
// the queue fills and req_tready drops. req_tready is low in the first clock out of reset.
// The csr registers are sampled while parsing, so change them only between numbers.
module integer_literal_parser #(
   parameter int MAX_DIGITS = ilp_pkg::ILP_MAX_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [63:0] value, [66:64] status, [74:67] stop_symbol
   output logic        rsp_tuser,   // [0] stopped_at_end
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [4:0]  csr_wdata
);
   import ilp_pkg::*;

   localparam logic [2:0] CSR_DEFAULT_RADIX = 3'd0;
   localparam logic [2:0] CSR_PREFIX_EN     = 3'd1;
   localparam logic [2:0] CSR_POS_ONLY      = 3'd2;
   localparam logic [2:0] CSR_COMMA_SKIP    = 3'd3;
   localparam logic [2:0] CSR_UNDER_SKIP    = 3'd4;
   localparam logic [2:0] CSR_SPACE_SKIP    = 3'd5;
   localparam logic [2:0] CSR_EXPLICIT_BND  = 3'd6;

   logic [RADIX_W-1:0] radix_ff;
   logic               prefix_en_ff;
   logic               pos_only_ff;
   logic               comma_skip_ff;
   logic               under_skip_ff;
   logic               space_skip_ff;
   logic               explicit_bnd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff        <= RADIX_DEC;
         prefix_en_ff    <= 1'b1;
         pos_only_ff     <= 1'b0;
         comma_skip_ff   <= 1'b0;
         under_skip_ff   <= 1'b0;
         space_skip_ff   <= 1'b1;
         explicit_bnd_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_DEFAULT_RADIX: radix_ff        <= csr_wdata;
            CSR_PREFIX_EN:     prefix_en_ff    <= csr_wdata[0];
            CSR_POS_ONLY:      pos_only_ff     <= csr_wdata[0];
            CSR_COMMA_SKIP:    comma_skip_ff   <= csr_wdata[0];
            CSR_UNDER_SKIP:    under_skip_ff   <= csr_wdata[0];
            CSR_SPACE_SKIP:    space_skip_ff   <= csr_wdata[0];
            CSR_EXPLICIT_BND:  explicit_bnd_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ilp_cfg_type cfg;

   always_comb begin
      cfg              = '0;
      // out-of-range radix falls back to decimal
      cfg.radix        = (radix_ff < 5'd2 || radix_ff > 5'd16) ? RADIX_DEC : radix_ff;
      cfg.prefix_en    = prefix_en_ff;
      cfg.pos_only     = pos_only_ff;
      cfg.comma_skip   = comma_skip_ff;
      cfg.under_skip   = under_skip_ff;
      cfg.space_skip   = space_skip_ff;
      cfg.explicit_bnd = explicit_bnd_ff;
   end

   logic         push_valid, push_ready;
   ilp_item_type push_data;
   logic         pop_valid, pop_ready;
   ilp_item_type pop_data;
   logic [63:0]  value;
   logic [2:0]   status;
   logic [7:0]   stop_sym;
   logic         at_end;

   ilp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ilp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ilp_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (value),
      .out_status (status),
      .out_stop   (stop_sym),
      .out_end    (at_end)
   );

   assign rsp_tdata = {5'd0, stop_sym, status, value};
   assign rsp_tuser = at_end;

endmodule

// ----- verif/integer_literal_parser_tb.sv -----
module integer_literal_parser_tb;
   import ilp_pkg::*;

   localparam int MAX_DIG        = ILP_MAX_DIGITS_DEFAULT;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   // register map
   localparam logic [2:0] REG_DEFAULT_RADIX = 3'd0;
   localparam logic [2:0] REG_PREFIX_EN     = 3'd1;
   localparam logic [2:0] REG_POS_ONLY      = 3'd2;
   localparam logic [2:0] REG_COMMA_SKIP    = 3'd3;
   localparam logic [2:0] REG_UNDER_SKIP    = 3'd4;
   localparam logic [2:0] REG_SPACE_SKIP    = 3'd5;
   localparam logic [2:0] REG_BND_CHECK     = 3'd6;
   localparam int         REG_COUNT         = 7;

   typedef enum logic [1:0] {LX_IDLE, LX_MINUS, LX_ZERO, LX_DIGITS} lex_phase_type;

   typedef struct packed {
      logic [4:0] radix;
      logic       prefix;
      logic       pos_only;
      logic       comma;
      logic       under;
      logic       space;
      logic       bnd_check;
   } lex_cfg_type;

   typedef struct packed {
      logic [63:0] value;
      logic [2:0]  status;
      logic [7:0]  stop;
      logic        at_end;
   } lit_result_type;

   localparam lex_cfg_type RESET_CFG = '{5'd10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

   // radix settings swept by the random phases, out-of-range values included
   localparam logic [4:0] RADIX_SWEEP [10] = '{5'd2, 5'd16, 5'd10, 5'd8, 5'd0,
                                               5'd31, 5'd1, 5'd17, 5'd10, 5'd16};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [4:0]  csr_wdata;

   integer_literal_parser #(
      .MAX_DIGITS(MAX_DIG)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // lexer shadow state
   lex_cfg_type   cur_cfg   = RESET_CFG;
   lex_phase_type lx_phase  = LX_IDLE;
   logic [63:0]   lx_acc    = '0;
   logic [4:0]    lx_radix  = RADIX_DEC;
   logic          lx_neg    = 1'b0;
   logic [6:0]    lx_count  = '0;

   lit_result_type lit_expected_q[$];

   int mismatches      = 0;
   int items_sent      = 0;
   int req_idle_pct    = 33;
   int rsp_idle_pct    = 33;
   int rsp_hold_cycles = 0;
   int stall_cycles    = 0;

   function automatic logic is_ws(input logic [7:0] c);
      return c == 8'd9 || c == 8'd10 || c == 8'd12 || c == 8'd13 || c == 8'd32;
   endfunction

   function automatic logic is_pn(input logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h2f) || (c >= 8'h3a && c <= 8'h40) ||
             (c >= 8'h5b && c <= 8'h60) || (c >= 8'h7b && c <= 8'h7e);
   endfunction

   function automatic logic [5:0] dig_val(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 6'(c - "0");
      if (c >= "a" && c <= "z") return 6'(c - "a" + 10);
      if (c >= "A" && c <= "Z") return 6'(c - "A" + 10);
      return 6'd36;
   endfunction

   function automatic logic [4:0] base_radix();
      if (cur_cfg.radix < 5'd2 || cur_cfg.radix > 5'd16) return RADIX_DEC;
      return cur_cfg.radix;
   endfunction

   function automatic void restart_number();
      lx_phase = LX_IDLE;
      lx_acc   = '0;
      lx_radix = base_radix();
      lx_neg   = 1'b0;
      lx_count = '0;
   endfunction

   function automatic void post_result(input logic [63:0] v, input logic [2:0] st,
                                       input logic [7:0] stop, input logic at_end);
      lit_result_type r;
      r.value  = v;
      r.status = st;
      r.stop   = stop;
      r.at_end = at_end;
      lit_expected_q.push_back(r);
      restart_number();
   endfunction

   function automatic void close_number(input logic [7:0] sym, input logic eoi);
      logic [63:0] signed_val;
      signed_val = lx_neg ? 64'd0 - lx_acc : lx_acc;
      if (eoi)
         post_result(signed_val, ST_OK, 8'd0, 1'b1);
      else if (cur_cfg.bnd_check && !(is_ws(sym) || is_pn(sym)))
         post_result(64'd0, ST_BAD_BOUNDARY, sym, 1'b0);
      else
         post_result(signed_val, ST_OK, sym, 1'b0);
   endfunction

   function automatic void eat_digit(input logic [7:0] sym);
      logic [5:0] d;
      if (is_ws(sym) || sym >= 8'h7f) begin
         close_number(sym, 1'b0);
         return;
      end
      if (sym == "," && cur_cfg.comma) return;
      if (sym == "_" && cur_cfg.under) return;
      d = dig_val(sym);
      if (d >= 6'(lx_radix)) begin
         close_number(sym, 1'b0);
         return;
      end
      lx_acc   = lx_acc * 64'(lx_radix) + 64'(d);
      lx_count = lx_count + 7'd1;
      if (lx_count >= 7'(MAX_DIG)) post_result(64'd0, ST_TOO_MANY, sym, 1'b0);
   endfunction

   function automatic void begin_number(input logic [7:0] sym);
      if (sym < "0" || sym > "9") begin
         post_result(64'd0, ST_BAD_START, sym, 1'b0);
         return;
      end
      if (sym == "0" && cur_cfg.prefix) begin
         lx_phase = LX_ZERO;
         return;
      end
      lx_phase = LX_DIGITS;
      eat_digit(sym);
   endfunction

   // advance the shadow lexer by one accepted transaction
   function automatic void lex_char(input logic [7:0] sym, input logic eoi);
      case (lx_phase)
         LX_MINUS: begin
            if (eoi) post_result(64'd0, ST_BAD_START, 8'd0, 1'b1);
            else begin_number(sym);
         end
         LX_ZERO: begin
            if (eoi) close_number(8'd0, 1'b1);
            else begin
               lx_phase = LX_DIGITS;
               if (sym == "x" || sym == "X") lx_radix = RADIX_HEX;
               else if (sym >= "0" && sym <= "7") begin
                  lx_radix = RADIX_OCT;
                  eat_digit(sym);
               end else begin
                  // the zero was a digit after all
                  lx_count = 7'd1;
                  eat_digit(sym);
               end
            end
         end
         LX_DIGITS: begin
            if (eoi) close_number(8'd0, 1'b1);
            else eat_digit(sym);
         end
         default: begin
            restart_number();
            if (eoi) post_result(64'd0, ST_BAD_START, 8'd0, 1'b1);
            else if (cur_cfg.space && is_ws(sym)) ;
            else if (sym == "-") begin
               if (cur_cfg.pos_only) post_result(64'd0, ST_MINUS_DENIED, sym, 1'b0);
               else begin
                  lx_neg   = 1'b1;
                  lx_phase = LX_MINUS;
               end
            end else begin_number(sym);
         end
      endcase
   endfunction

   function automatic void note_failure(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want)
         note_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
   endfunction

   // result checker
   always @(posedge clock) begin : rsp_check
      lit_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (lit_expected_q.size() == 0)
            note_failure($sformatf("unexpected transaction: tdata %h tuser %b",
                                   rsp_tdata, rsp_tuser));
         else begin
            want = lit_expected_q.pop_front();
            check_field("value", want.value, rsp_tdata[63:0]);
            check_field("status", 64'(want.status), 64'(rsp_tdata[66:64]));
            check_field("stop_symbol", 64'(want.stop), 64'(rsp_tdata[74:67]));
            check_field("stopped_at_end", 64'(want.at_end), 64'(rsp_tuser));
         end
      end
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   initial begin : rsp_sink
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // called at a rising edge; returns at the edge that accepted the transaction
   task automatic send_char(input logic [7:0] ch, input logic eoi);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      lex_char(ch, eoi);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_char(8'($urandom_range(255)), 1'b1);
   endtask

   // wait until every pending number has come out and the pipeline is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (lit_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input lex_cfg_type c);
      logic [4:0] vals [REG_COUNT];
      vals[REG_DEFAULT_RADIX] = c.radix;
      vals[REG_PREFIX_EN]     = 5'(c.prefix);
      vals[REG_POS_ONLY]      = 5'(c.pos_only);
      vals[REG_COMMA_SKIP]    = 5'(c.comma);
      vals[REG_UNDER_SKIP]    = 5'(c.under);
      vals[REG_SPACE_SKIP]    = 5'(c.space);
      vals[REG_BND_CHECK]     = 5'(c.bnd_check);
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      cur_cfg = c;
   endtask

   function automatic lex_cfg_type rand_config(input logic [4:0] radix);
      lex_cfg_type c;
      c.radix     = radix;
      c.prefix    = 1'($urandom_range(1));
      c.pos_only  = 1'($urandom_range(1));
      c.comma     = 1'($urandom_range(1));
      c.under     = 1'($urandom_range(1));
      c.space     = 1'($urandom_range(1));
      c.bnd_check = 1'($urandom_range(1));
      return c;
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(4))
         0: return 8'd9;
         1: return 8'd10;
         2: return 8'd12;
         3: return 8'd13;
         default: return 8'd32;
      endcase
   endfunction

   function automatic logic [7:0] digit_char(input int radix);
      int v;
      v = int'($urandom_range(radix - 1));
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(1) != 0 ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [7:0] stop_char();
      string pn;
      pn = ".;:+)#/!@[`{~";
      case ($urandom_range(4))
         0: return space_char();
         1: return pn[$urandom_range(pn.len() - 1)];
         2: return 8'($urandom_range(8'h7f, 8'hff));
         3: return 8'($urandom_range("g", "z"));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one literal: optional spaces, sign and prefix, digits with separators, a stop
   task automatic send_literal();
      int radix;
      int len;
      radix = int'(base_radix());
      if (cur_cfg.space) repeat ($urandom_range(2)) send_char(space_char(), 1'b0);
      if ($urandom_range(3) == 0) send_char("-", 1'b0);
      case ($urandom_range(4))
         0: begin
            send_char("0", 1'b0);
            send_char($urandom_range(1) != 0 ? "x" : "X", 1'b0);
            radix = 16;
         end
         1: begin
            send_char("0", 1'b0);
            radix = 8;
         end
         default:
            send_char(8'("0" + $urandom_range(1, (radix < 10 ? radix : 10) - 1)), 1'b0);
      endcase
      len = ($urandom_range(19) == 0) ? int'($urandom_range(60, 70))
                                      : int'($urandom_range(0, 16));
      repeat (len) begin
         if ($urandom_range(9) == 0) send_char($urandom_range(1) != 0 ? "," : "_", 1'b0);
         else send_char(digit_char(radix), 1'b0);
      end
      if ($urandom_range(5) == 0) send_end();
      else send_char(stop_char(), 1'b0);
   endtask

   task automatic run_phase(input int goal);
      int sent0;
      sent0 = items_sent;
      while (items_sent - sent0 < goal) begin
         if ($urandom_range(9) < 8) send_literal();
         else send_char(8'($urandom_range(255)), $urandom_range(15) == 0);
      end
      send_end();
   endtask

   task automatic test_basic_forms();
      settle();
      apply_config(RESET_CFG);
      send_text("  -0x7fFF ");
      send_text("017;");
      send_text("09 ");
      send_text("0");
      send_end();
      send_text("-");
      send_end();
      send_end();
      send_text("a");
      send_text("12");
      send_char(8'hff, 1'b0);
      send_text("1,2 ");
      send_char(8'h00, 1'b0);
      send_text("18446744073709551617 ");
      send_text("0X1g");
      send_text("0x");
      send_end();
      send_text("0_");
      settle();
   endtask

   task automatic test_mode_flags();
      lex_cfg_type c;
      c = '{5'd10, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      settle();
      apply_config(c);
      send_text("-5 ");
      send_text(" 7");
      send_end();
      send_text("12a");
      send_text("1,000_000.");
      send_text("9");
      send_char(8'h80, 1'b0);
      send_text("-0x");
      send_end();
      send_end();
   endtask

   task automatic test_radix_extremes();
      lex_cfg_type c;
      c = '{5'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      settle();
      apply_config(c);
      send_text("0101 ");
      send_text("7 ");
      c.radix = 5'd16;
      settle();
      apply_config(c);
      send_text("9fA ");
      send_text("0x5 ");
      c.radix = 5'd31;
      settle();
      apply_config(c);
      send_text("99 ");
      c.radix = 5'd0;
      settle();
      apply_config(c);
      send_text("42");
      send_end();
      settle();
   endtask

   task automatic test_digit_limit();
      settle();
      apply_config(RESET_CFG);
      repeat (MAX_DIG) send_char("1", 1'b0);
      send_text("0x");
      repeat (MAX_DIG - 1) send_char("f", 1'b0);
      send_char(".", 1'b0);
      send_text("0X");
      repeat (MAX_DIG) send_char("F", 1'b0);
      // lone zero counts toward the limit
      send_char("0", 1'b0);
      repeat (MAX_DIG - 1) send_char("9", 1'b0);
      send_char("0", 1'b0);
      repeat (MAX_DIG - 1) send_char("7", 1'b0);
      send_end();
      settle();
   endtask

   task automatic test_backpressure();
      settle();
      apply_config(RESET_CFG);
      rsp_hold_cycles = 200;
      repeat (40) send_text("7;");
      send_end();
      settle();
   endtask

   task automatic test_random_mix();
      for (int p = 0; p < 10; p++) begin
         settle();
         apply_config(rand_config(RADIX_SWEEP[p]));
         if (p == 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 33;
            rsp_idle_pct = 33;
         end
         run_phase(30);
      end
      req_idle_pct = 33;
      rsp_idle_pct = 33;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'd0;
      req_tuser  <= 1'b0;
      csr_wen    <= 1'b0;
      csr_index  <= REG_DEFAULT_RADIX;
      csr_wdata  <= 5'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_forms();
      test_mode_flags();
      test_radix_extremes();
      test_digit_limit();
      test_backpressure();
      test_random_mix();
      settle();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
